### sv/rgm_pkg.sv
// Shared types and constants for the residue group random atom mask.
// Used by the atom channel interface and the top level; depends on nothing.
`default_nettype none

package rgm_pkg;

  localparam int NAME_W      = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  // Protein tag kept with every residue entry; zero never matches.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam logic [CFG_INDEX_W-1:0] REG_REMOVAL_THRESHOLD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAIN_BASE          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTRAL_CHAIN       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTRAL_SITE        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKBONE_COUNT      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKBONE_NAMES_LOW  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKBONE_NAMES_HIGH = 3'd6;

  localparam logic [7:0] CHAIN_BASE_RESET    = 8'd65;
  localparam logic [7:0] CENTRAL_CHAIN_RESET = 8'd65;
  localparam logic [2:0] BACKBONE_COUNT_RESET = 3'd4;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               removed;
  } mark_t;

  typedef struct packed {
    logic keep_atom;
    logic index_error;
    logic is_last;
  } verdict_t;

endpackage

`default_nettype wire

### sv/rgm_atom_if.sv
// Atom input channel: valid/ready handshake with one atom per beat.
// Depends on rgm_pkg.
`default_nettype none

interface rgm_atom_if #(
  parameter int RANDOM_BITS = 16
) ();
  logic                       valid;
  logic                       ready;
  logic [7:0]                 chain_code;
  logic signed [15:0]         site;
  logic [rgm_pkg::NAME_W-1:0] atom_name;
  logic [RANDOM_BITS-1:0]     random_draw;
  logic                       last_atom;

  modport source (
    output valid, chain_code, site, atom_name, random_draw, last_atom,
    input  ready
  );

  modport sink (
    input  valid, chain_code, site, atom_name, random_draw, last_atom,
    output ready
  );
endinterface

`default_nettype wire

### sv/rgm_verdict_if.sv
// Verdict output channel: valid/ready handshake with one result per beat.
// Standalone; no package dependency.
`default_nettype none

interface rgm_verdict_if ();
  logic valid;
  logic ready;
  logic keep_atom;
  logic index_error;
  logic is_last;

  modport source (
    output valid, keep_atom, index_error, is_last,
    input  ready
  );

  modport sink (
    input  valid, keep_atom, index_error, is_last,
    output ready
  );
endinterface

`default_nettype wire

### sv/rgm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none

module rgm_ram #(
  parameter int  WIDTH  = 9,
  parameter int  DEPTH  = 131072,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/rgm_index.sv
// Four-stage residue index pipeline: (chain - base) * sites + site, then a
// truncated remainder by the table depth via reciprocal multiply. Standalone.
`default_nettype none

module rgm_index #(
  parameter int  SITES_PER_CHAIN = 8192,
  parameter int  CHAIN_SLOTS     = 16,
  localparam int DEPTH  = CHAIN_SLOTS * SITES_PER_CHAIN,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [7:0]        chain,
  input  wire logic [7:0]        base,
  input  wire logic signed [15:0] site,
  output logic      [ADDR_W-1:0] idx,
  output logic                   neg
);

  localparam int MAG_W = $clog2(255 * SITES_PER_CHAIN + 32769);
  localparam int RAW_W = MAG_W + 1;
  localparam int RECIP = (1 << MAG_W) / DEPTH;
  localparam logic [MAG_W-1:0]        RECIP_C = MAG_W'(RECIP);
  localparam logic [MAG_W-1:0]        DEPTH_C = MAG_W'(DEPTH);
  localparam logic signed [RAW_W-1:0] SITES_C = RAW_W'(SITES_PER_CHAIN);

  logic signed [8:0]       diff;
  logic signed [RAW_W-1:0] raw;
  logic [RAW_W-1:0]        raw_neg;
  logic [MAG_W-1:0]        mag;
  logic [2*MAG_W-1:0]      prod_q;
  logic [2*MAG_W-1:0]      prod_r;
  logic                    over;
  logic [MAG_W-1:0]        rem;

  logic [MAG_W-1:0] mag1, mag2, quot2, rem3;
  logic             neg1, neg2, neg3;

  always_comb begin
    diff    = $signed({1'b0, chain}) - $signed({1'b0, base});
    raw     = $signed({{(RAW_W-9){diff[8]}}, diff}) * SITES_C
            + $signed({{(RAW_W-16){site[15]}}, site});
    raw_neg = -raw;
    mag     = raw[RAW_W-1] ? raw_neg[MAG_W-1:0] : raw[MAG_W-1:0];
    prod_q  = {{MAG_W{1'b0}}, mag1} * {{MAG_W{1'b0}}, RECIP_C};
    prod_r  = {{MAG_W{1'b0}}, quot2} * {{MAG_W{1'b0}}, DEPTH_C};
    over    = rem3 >= DEPTH_C;
    rem     = over ? rem3 - DEPTH_C : rem3;
  end

  // quotient estimate is exact or one low, so one correction step suffices
  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= mag;
      neg1  <= raw[RAW_W-1];
      mag2  <= mag1;
      quot2 <= prod_q[2*MAG_W-1:MAG_W];
      neg2  <= neg1;
      rem3  <= mag2 - prod_r[MAG_W-1:0];
      neg3  <= neg2;
      idx   <= rem[ADDR_W-1:0];
      neg   <= neg3 && (rem != '0);
    end
  end

endmodule

`default_nettype wire

### sv/residue_group_random_atom_mask_core.sv
// Residue group random atom mask: five-stage pipeline, one atom per cycle
// unless a clearing pass or full output skid stalls it. The mark table RAM
// does one read-modify-write per atom with forwarding from the write stage.
// After reset, and after every 255th protein, a clearing pass writes all
// CHAIN_SLOTS*SITES_PER_CHAIN entries, one per cycle, with atom ready low.
// Synchronous active-high reset; config writes are taken whenever not in reset.
`default_nettype none

module residue_group_random_atom_mask_core #(
  parameter int SITES_PER_CHAIN = 8192,
  parameter int CHAIN_SLOTS     = 16,
  parameter int BACKBONE_SLOTS  = 4,
  parameter int RANDOM_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic                                cfg_we,
  input  wire logic [rgm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [rgm_pkg::CFG_DATA_W-1:0]      cfg_data,
  rgm_atom_if.sink                                 atom,
  rgm_verdict_if.source                            verdict
);

  localparam int DEPTH  = CHAIN_SLOTS * SITES_PER_CHAIN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int THR_W  = RANDOM_BITS + 1;
  localparam int MARK_W = $bits(rgm_pkg::mark_t);
  localparam logic [ADDR_W-1:0] CLR_END  = ADDR_W'(DEPTH - 1);
  localparam logic [2:0]        BB_SLOTS = 3'(BACKBONE_SLOTS);

  typedef struct packed {
    logic bb;
    logic below;
    logic last;
  } side_t;

  // configuration
  logic [THR_W-1:0]                 removal_threshold;
  logic [7:0]                       chain_base;
  logic [7:0]                       central_chain;
  logic signed [15:0]               central_site;
  logic [2:0]                       backbone_count;
  logic [rgm_pkg::NAME_W-1:0]       bb_names [BACKBONE_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      removal_threshold <= '0;
      chain_base        <= rgm_pkg::CHAIN_BASE_RESET;
      central_chain     <= rgm_pkg::CENTRAL_CHAIN_RESET;
      central_site      <= '0;
      backbone_count    <= rgm_pkg::BACKBONE_COUNT_RESET;
      for (int i = 0; i < BACKBONE_SLOTS; i++) begin
        bb_names[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rgm_pkg::REG_REMOVAL_THRESHOLD: removal_threshold <= cfg_data[THR_W-1:0];
        rgm_pkg::REG_CHAIN_BASE:        chain_base        <= cfg_data[7:0];
        rgm_pkg::REG_CENTRAL_CHAIN:     central_chain     <= cfg_data[7:0];
        rgm_pkg::REG_CENTRAL_SITE:      central_site      <= cfg_data[15:0];
        rgm_pkg::REG_BACKBONE_COUNT:    backbone_count    <= cfg_data[2:0];
        rgm_pkg::REG_BACKBONE_NAMES_LOW: begin
          for (int i = 0; i < BACKBONE_SLOTS; i++) begin
            if (i < 2) begin
              bb_names[i] <= cfg_data[32*(i%2) +: 32];
            end
          end
        end
        rgm_pkg::REG_BACKBONE_NAMES_HIGH: begin
          for (int i = 0; i < BACKBONE_SLOTS; i++) begin
            if (i >= 2) begin
              bb_names[i] <= cfg_data[32*(i%2) +: 32];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                  en;
  logic                  v1, v2, v3, v4, v5;
  logic [1:0]            cnt;
  logic                  clr_active;
  logic [ADDR_W-1:0]     clr_addr;

  assign en         = !clr_active && (cnt != 2'd2);
  assign atom.ready = en;

  // stage 1 side info
  logic [2:0] bb_limit;
  logic       bb_hit;
  side_t      side_in;
  side_t      side_q [5];

  always_comb begin
    bb_limit = (backbone_count > BB_SLOTS) ? BB_SLOTS : backbone_count;
    bb_hit   = 1'b0;
    for (int i = 0; i < BACKBONE_SLOTS; i++) begin
      if ((3'(i) < bb_limit) && (bb_names[i] == atom.atom_name)) begin
        bb_hit = 1'b1;
      end
    end
    side_in.bb    = bb_hit;
    side_in.below = {1'b0, atom.random_draw} < removal_threshold;
    side_in.last  = atom.last_atom;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < 5; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= atom.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // residue indexes, stages 1 to 4
  logic [ADDR_W-1:0] idx4, cidx4;
  logic              neg4, cneg4;

  rgm_index #(
    .SITES_PER_CHAIN(SITES_PER_CHAIN),
    .CHAIN_SLOTS    (CHAIN_SLOTS)
  ) u_atom_index (
    .clk  (clk),
    .en   (en),
    .chain(atom.chain_code),
    .base (chain_base),
    .site (atom.site),
    .idx  (idx4),
    .neg  (neg4)
  );

  rgm_index #(
    .SITES_PER_CHAIN(SITES_PER_CHAIN),
    .CHAIN_SLOTS    (CHAIN_SLOTS)
  ) u_central_index (
    .clk  (clk),
    .en   (en),
    .chain(central_chain),
    .base (chain_base),
    .site (central_site),
    .idx  (cidx4),
    .neg  (cneg4)
  );

  // stage 5: mark table read-modify-write
  logic [ADDR_W-1:0]          idx5;
  logic                       neg5;
  logic                       cmatch5;
  logic                       fwd5;
  logic                       flush5;
  rgm_pkg::mark_t             fwd_data5;
  logic [rgm_pkg::EPOCH_W-1:0] epoch;
  logic                       err_latch;

  logic [MARK_W-1:0] rd_raw;
  rgm_pkg::mark_t    rd_mark;
  rgm_pkg::mark_t    entry;
  rgm_pkg::mark_t    wmark;
  logic              seen;
  logic              removed;
  logic              keep;
  logic              err_out;
  logic              wr_pipe;
  logic              retire;
  logic              start_clr;

  always_comb begin
    rd_mark   = rd_raw;
    entry     = flush5 ? '0 : (fwd5 ? fwd_data5 : rd_mark);
    seen      = entry.epoch == epoch;
    removed   = seen ? entry.removed : (side_q[4].below || cmatch5);
    wmark     = '{epoch: epoch, removed: removed};
    retire    = en && v5;
    wr_pipe   = retire && !err_latch && !neg5;
    keep      = !err_latch && !neg5 && (side_q[4].bb || !removed);
    err_out   = err_latch || neg5;
    start_clr = retire && side_q[4].last && (epoch == rgm_pkg::EPOCH_LAST);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx5      <= idx4;
      neg5      <= neg4;
      cmatch5   <= !cneg4 && (cidx4 == idx4);
      fwd5      <= wr_pipe && (idx5 == idx4);
      fwd_data5 <= wmark;
    end
  end

  // stage-5 read data taken before a clearing pass is stale
  always_ff @(posedge clk) begin
    if (rst) begin
      flush5 <= 1'b0;
    end else if (start_clr) begin
      flush5 <= 1'b1;
    end else if (en) begin
      flush5 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= rgm_pkg::EPOCH_FIRST;
      err_latch <= 1'b0;
    end else if (retire) begin
      err_latch <= side_q[4].last ? 1'b0 : (err_latch || neg5);
      if (side_q[4].last) begin
        epoch <= (epoch == rgm_pkg::EPOCH_LAST) ? rgm_pkg::EPOCH_FIRST : epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (start_clr) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == CLR_END) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  rgm_ram #(
    .WIDTH(MARK_W),
    .DEPTH(DEPTH)
  ) u_mark_ram (
    .clk  (clk),
    .we   (clr_active || wr_pipe),
    .waddr(clr_active ? clr_addr : idx5),
    .wdata(clr_active ? MARK_W'(0) : MARK_W'(wmark)),
    .re   (en && v4),
    .raddr(idx4),
    .rdata(rd_raw)
  );

  // two-entry output skid
  rgm_pkg::verdict_t res, q0, q1;
  logic              pop;

  always_comb begin
    res.keep_atom   = keep;
    res.index_error = err_out;
    res.is_last     = side_q[4].last;
    pop             = verdict.valid && verdict.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 2'(retire) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (retire && ((cnt == 2'd0) || ((cnt == 2'd1) && pop))) begin
      q0 <= res;
    end else if (pop) begin
      q0 <= q1;
    end
    if (retire && (cnt == 2'd1) && !pop) begin
      q1 <= res;
    end
  end

  assign verdict.valid       = cnt != 2'd0;
  assign verdict.keep_atom   = q0.keep_atom;
  assign verdict.index_error = q0.index_error;
  assign verdict.is_last     = q0.is_last;

  a_last_clears_error: assert property (@(posedge clk) disable iff (rst)
    (retire && side_q[4].last) |=> !err_latch)
    else $error("error latch survived end of protein");

  a_epoch_only_at_last: assert property (@(posedge clk) disable iff (rst)
    (retire && !side_q[4].last) |=> $stable(epoch))
    else $error("epoch moved without a last atom");

  a_keep_not_error: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> !(verdict.keep_atom && verdict.index_error))
    else $error("kept atom flagged with index error");

  a_clear_from_wrap: assert property (@(posedge clk) disable iff (rst)
    $rose(clr_active) |-> $past(start_clr))
    else $error("clearing pass started without epoch wrap");

endmodule

`default_nettype wire
